FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted key table
// Field widths, operation and status codes, item structs and the control
// bundle that the table drives into every cell of the row.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int KEY_W = 34;
	localparam int PAY_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_DUPLICATE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] position;
		logic [PAY_W-1:0] found_payload;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// Control that every cell of the row sees in the same cycle.
	typedef struct packed {
		logic capture; // latch compare flags against the incoming key
		logic ins;     // open a slot at the insert point and shift up
		logic del;     // close the slot of the matching record and shift down
	} cell_ctl_t;

endpackage

FILE: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one record slot of the sorted key table
// Holds a key and payload, compares its key against an incoming key, and
// takes data from a neighbor when the row shifts on insert or delete.
// ----------------------------------------------------------------------------
module skt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  skt_pkg::cell_ctl_t           ctl,
	input  logic                         occ,
	input  logic [skt_pkg::KEY_W-1:0]    cmp_key,
	input  logic [skt_pkg::KEY_W-1:0]    new_key,
	input  logic [skt_pkg::PAY_W-1:0]    new_pay,
	input  logic                         prev_lt,
	input  logic [skt_pkg::KEY_W-1:0]    prev_key,
	input  logic [skt_pkg::PAY_W-1:0]    prev_pay,
	input  logic [skt_pkg::KEY_W-1:0]    next_key,
	input  logic [skt_pkg::PAY_W-1:0]    next_pay,
	output logic [skt_pkg::KEY_W-1:0]    key_q,
	output logic [skt_pkg::PAY_W-1:0]    pay_q,
	output logic                         lt_s1,
	output logic                         eq_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (ctl.capture) begin
			lt_s1 <= occ && (key_q < cmp_key);
			eq_s1 <= occ && (key_q == cmp_key);
		end
	end

	// The first cell at or above the insert point takes the new record; the
	// cells behind it take their lower neighbor. Delete pulls from above.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_s1) begin
			if (prev_lt) begin
				key_q <= new_key;
				pay_q <= new_pay;
			end else begin
				key_q <= prev_key;
				pay_q <= prev_pay;
			end
		end else if (ctl.del && !lt_s1) begin
			key_q <= next_key;
			pay_q <= next_pay;
		end
	end

endmodule

FILE: rtl/sorted_key_table.sv
// The request and the compare flags are registered when a request is taken;
// the row shifts and the result item is registered when the request fires,
// which waits while an earlier result is held at the output. A new request
// is taken only once the current one fires: its compare needs the shifted row.
// Reset clears the record count and the handshake state; record contents are
// not cleared, and only slots below the count are ever looked at.
// ----------------------------------------------------------------------------
// sorted_key_table: ordered record table with insert, search and delete
// A row of DEPTH cells keeps records in ascending key order. Every cell
// compares against the request key at once, and the row shifts in one step.
// ----------------------------------------------------------------------------
module sorted_key_table #(
	parameter int DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  skt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output skt_pkg::rsp_t  rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                      busy_q;
	skt_pkg::req_t             op_s1;
	logic [CW-1:0]             count_q;
	logic                      rsp_valid_q;
	skt_pkg::rsp_t             rsp_q;

	logic                      accept;
	logic                      fire;
	logic                      hit;
	logic                      full;
	logic                      ins_ok;
	logic                      del_ok;
	logic [IW-1:0]             idx;
	logic [skt_pkg::PAY_W-1:0] hit_pay;
	skt_pkg::rsp_t             rsp_d;
	skt_pkg::cell_ctl_t        ctl;

	logic [DEPTH-1:0]          occ;
	logic [DEPTH-1:0]          lt;
	logic [DEPTH-1:0]          eq;
	logic [DEPTH-1:0]          bnd;
	logic [skt_pkg::KEY_W-1:0] cell_key [DEPTH];
	logic [skt_pkg::PAY_W-1:0] cell_pay [DEPTH];

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;
	assign fire      = busy_q && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ctl.capture = accept;
	assign ctl.ins     = fire && ins_ok;
	assign ctl.del     = fire && del_ok;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			assign occ[i] = (CW'(i) < count_q);
			if (i == 0) begin : g_first
				assign bnd[i] = !lt[i];
				skt_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.occ      (occ[i]),
					.cmp_key  (req.key),
					.new_key  (op_s1.key),
					.new_pay  (op_s1.payload),
					.prev_lt  (1'b1),
					.prev_key (op_s1.key),
					.prev_pay (op_s1.payload),
					.next_key (cell_key[(i + 1) % DEPTH]),
					.next_pay (cell_pay[(i + 1) % DEPTH]),
					.key_q    (cell_key[i]),
					.pay_q    (cell_pay[i]),
					.lt_s1    (lt[i]),
					.eq_s1    (eq[i])
				);
			end else begin : g_rest
				assign bnd[i] = !lt[i] && lt[i-1];
				skt_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.ctl      (ctl),
					.occ      (occ[i]),
					.cmp_key  (req.key),
					.new_key  (op_s1.key),
					.new_pay  (op_s1.payload),
					.prev_lt  (lt[i-1]),
					.prev_key (cell_key[i-1]),
					.prev_pay (cell_pay[i-1]),
					.next_key (cell_key[(i + 1 < DEPTH) ? i + 1 : i]),
					.next_pay (cell_pay[(i + 1 < DEPTH) ? i + 1 : i]),
					.key_q    (cell_key[i]),
					.pay_q    (cell_pay[i]),
					.lt_s1    (lt[i]),
					.eq_s1    (eq[i])
				);
			end
		end
	endgenerate

	// Keys are unique and sorted, so at most one cell matches and the compare
	// flags form a prefix with a single boundary; both encode by OR.
	always_comb begin
		idx     = '0;
		hit_pay = '0;
		for (int n = 0; n < DEPTH; n++) begin
			if (hit ? eq[n] : bnd[n]) begin
				idx = idx | IW'(n);
			end
			if (eq[n]) begin
				hit_pay = hit_pay | cell_pay[n];
			end
		end
	end

	assign hit  = |eq;
	assign full = (count_q == CW'(DEPTH));

	always_comb begin
		rsp_d               = '0;
		rsp_d.status        = skt_pkg::ST_NOT_FOUND;
		rsp_d.entry_count   = skt_pkg::CNT_W'(count_q);
		ins_ok              = 1'b0;
		del_ok              = 1'b0;
		unique case (op_s1.kind)
			skt_pkg::KIND_INSERT: begin
				if (full) begin
					rsp_d.status = skt_pkg::ST_FULL;
				end else if (hit) begin
					rsp_d.status   = skt_pkg::ST_DUPLICATE;
					rsp_d.position = skt_pkg::POS_W'(idx);
				end else begin
					ins_ok            = 1'b1;
					rsp_d.status      = skt_pkg::ST_DONE;
					rsp_d.position    = skt_pkg::POS_W'(idx);
					rsp_d.entry_count = skt_pkg::CNT_W'(count_q + 1'b1);
				end
			end
			skt_pkg::KIND_SEARCH: begin
				if (hit) begin
					rsp_d.status        = skt_pkg::ST_DONE;
					rsp_d.position      = skt_pkg::POS_W'(idx);
					rsp_d.found_payload = hit_pay;
				end
			end
			skt_pkg::KIND_DELETE: begin
				if (hit) begin
					del_ok            = 1'b1;
					rsp_d.status      = skt_pkg::ST_DONE;
					rsp_d.position    = skt_pkg::POS_W'(idx);
					rsp_d.entry_count = skt_pkg::CNT_W'(count_q - 1'b1);
				end
			end
			default: begin
				rsp_d.status = skt_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.del) begin
				count_q <= count_q - 1'b1;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("record count above table depth");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(eq))
		else $error("more than one cell matches the key");

	a_single_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(bnd))
		else $error("compare flags do not form a prefix");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the record count");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> count_q == $past(count_q) - 1'b1)
		else $error("delete did not shrink the record count");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted key table
// Streams insert, search and delete requests with random gaps on both sides,
// keeps a model of the ordered record array and checks every result in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH = 64;
	localparam int LIMIT_CYCLES = 300000;
	localparam int ITEM_TARGET = 470;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [skt_pkg::KEY_W-1:0] KEY_TOP = '1;
	localparam logic [skt_pkg::KEY_W-1:0] KEY_DEC_TOP = 34'd9999999999;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	skt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	skt_pkg::rsp_t rsp;

	// Model of the table contents.
	logic [skt_pkg::KEY_W-1:0] tbl_key [DEPTH];
	logic [skt_pkg::PAY_W-1:0] tbl_pay [DEPTH];
	int tbl_count = 0;

	skt_pkg::req_t pending_req [$];
	skt_pkg::rsp_t expected_rsp [$];
	logic [skt_pkg::KEY_W-1:0] key_pool [$];
	skt_pkg::rsp_t want;

	bit req_accepted = 1'b0;
	bit drv_busy = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int error_count = 0;
	int queued_items = 0;
	int cycle_count;

	sorted_key_table #(.DEPTH(DEPTH)) i_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [skt_pkg::KEY_W-1:0] rand_key();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return '0;
			1: return KEY_TOP;
			2, 3: return skt_pkg::KEY_W'($urandom_range(0, 63));
			default: return w[skt_pkg::KEY_W-1:0];
		endcase
	endfunction

	function automatic logic [skt_pkg::PAY_W-1:0] rand_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Picks a key that was inserted earlier, so searches and deletes mostly hit.
	function automatic logic [skt_pkg::KEY_W-1:0] take_pool_key(input bit remove);
		int i;
		logic [skt_pkg::KEY_W-1:0] k;
		if (key_pool.size() == 0) return rand_key();
		i = $urandom_range(0, key_pool.size() - 1);
		k = key_pool[i];
		if (remove) key_pool.delete(i);
		return k;
	endfunction

	// Applies one request to the model and returns the result it must give.
	function automatic skt_pkg::rsp_t table_apply(input skt_pkg::req_t r);
		skt_pkg::rsp_t res;
		int idx;
		int j;
		bit hit;
		res = '0;
		res.status = skt_pkg::ST_NOT_FOUND;
		idx = 0;
		while (idx < tbl_count && tbl_key[idx] < r.key) idx++;
		hit = (idx < tbl_count) && (tbl_key[idx] == r.key);
		case (r.kind)
			skt_pkg::KIND_INSERT: begin
				// A full table is reported even when the key is already present.
				if (tbl_count >= DEPTH) begin
					res.status = skt_pkg::ST_FULL;
				end else if (hit) begin
					res.status = skt_pkg::ST_DUPLICATE;
					res.position = skt_pkg::POS_W'(idx);
				end else begin
					for (j = tbl_count; j > idx; j--) begin
						tbl_key[j] = tbl_key[j-1];
						tbl_pay[j] = tbl_pay[j-1];
					end
					tbl_key[idx] = r.key;
					tbl_pay[idx] = r.payload;
					tbl_count++;
					res.status = skt_pkg::ST_DONE;
					res.position = skt_pkg::POS_W'(idx);
				end
			end
			skt_pkg::KIND_SEARCH: begin
				if (hit) begin
					res.status = skt_pkg::ST_DONE;
					res.position = skt_pkg::POS_W'(idx);
					res.found_payload = tbl_pay[idx];
				end
			end
			skt_pkg::KIND_DELETE: begin
				if (hit) begin
					for (j = idx; j + 1 < tbl_count; j++) begin
						tbl_key[j] = tbl_key[j+1];
						tbl_pay[j] = tbl_pay[j+1];
					end
					tbl_count--;
					res.status = skt_pkg::ST_DONE;
					res.position = skt_pkg::POS_W'(idx);
				end
			end
			default: begin
			end
		endcase
		res.entry_count = skt_pkg::CNT_W'(tbl_count);
		return res;
	endfunction

	task automatic queue_req(input logic [1:0] kind, input logic [skt_pkg::KEY_W-1:0] key,
			input logic [skt_pkg::PAY_W-1:0] payload);
		skt_pkg::req_t item;
		item.kind = kind;
		item.key = key;
		item.payload = payload;
		pending_req.push_back(item);
		queued_items++;
	endtask

	task automatic flag_mismatch(input string msg);
		error_count++;
		if (error_count <= 10) $display("%s", msg);
	endtask

	task automatic wait_drained();
		while (pending_req.size() != 0 || drv_busy) @(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
	endtask

	// Request driver: holds each item until it is taken, then waits out a gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_accepted) begin
				req_accepted = 1'b0;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_req.size() > 0) begin
					req <= pending_req.pop_front();
					drv_busy = 1'b1;
					send_gap = calm ? 0 : idle_len();
				end
			end
			req_valid <= drv_busy;
		end
	end

	// Result sink: stalls at random, independent of whether a result is waiting.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
		end
	end

	// Monitor: results are checked before a request taken at the same edge is
	// predicted, so a premature result cannot pair with its own expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					flag_mismatch($sformatf(
						"unexpected result: status %0d position %0d payload %h count %0d",
						rsp.status, rsp.position, rsp.found_payload, rsp.entry_count));
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status || rsp.position !== want.position ||
							rsp.found_payload !== want.found_payload ||
							rsp.entry_count !== want.entry_count) begin
						flag_mismatch($sformatf(
							"mismatch exp/act: status %0d/%0d pos %0d/%0d payload %h/%h count %0d/%0d",
							want.status, rsp.status, want.position, rsp.position,
							want.found_payload, rsp.found_payload, want.entry_count, rsp.entry_count));
					end
				end
			end
			if (req_valid && req_ready) begin
				expected_rsp.push_back(table_apply(req));
				req_accepted = 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int phase_no;
		int n;
		int r;
		logic [skt_pkg::KEY_W-1:0] k;

		// Directed: empty table, key extremes, duplicates, shifts and the unused kind.
		queue_req(skt_pkg::KIND_SEARCH, 34'd5, '0);
		queue_req(skt_pkg::KIND_DELETE, 34'd5, '0);
		queue_req(skt_pkg::KIND_INSERT, '0, '0);
		queue_req(skt_pkg::KIND_INSERT, KEY_TOP, '1);
		queue_req(skt_pkg::KIND_INSERT, KEY_DEC_TOP, 32'h1234_5678);
		queue_req(skt_pkg::KIND_INSERT, '0, 32'hdead_beef);
		queue_req(skt_pkg::KIND_SEARCH, KEY_TOP, 32'h5555_5555);
		queue_req(skt_pkg::KIND_SEARCH, '0, '0);
		queue_req(skt_pkg::KIND_SEARCH, KEY_DEC_TOP, '0);
		queue_req(KIND_UNUSED, '0, '1);
		queue_req(skt_pkg::KIND_INSERT, 34'd5, 32'ha5a5_a5a5);
		queue_req(skt_pkg::KIND_SEARCH, KEY_DEC_TOP, '0);
		queue_req(skt_pkg::KIND_SEARCH, 34'd6, '0);
		queue_req(skt_pkg::KIND_DELETE, '0, '1);
		queue_req(skt_pkg::KIND_DELETE, '0, '0);
		queue_req(skt_pkg::KIND_SEARCH, 34'd5, '0);
		queue_req(skt_pkg::KIND_DELETE, KEY_TOP, '0);
		queue_req(skt_pkg::KIND_DELETE, 34'd5, '0);
		queue_req(skt_pkg::KIND_DELETE, KEY_DEC_TOP, '0);
		queue_req(KIND_UNUSED, KEY_TOP, '1);
		queue_req(skt_pkg::KIND_SEARCH, KEY_TOP, '0);
		wait_drained();

		phase_no = 0;
		while (queued_items < ITEM_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			case (phase_no % 4)
				1: begin
					// Fill past capacity so that full-table rejections occur.
					for (n = 0; n < 72; n++) begin
						k = ($urandom_range(0, 9) == 0) ? take_pool_key(1'b0) : rand_key();
						key_pool.push_back(k);
						queue_req(skt_pkg::KIND_INSERT, k, rand_payload());
					end
					for (n = 0; n < 15; n++) begin
						queue_req(skt_pkg::KIND_SEARCH, take_pool_key(1'b0), rand_payload());
					end
					queue_req(KIND_UNUSED, rand_key(), rand_payload());
				end
				3: begin
					while (key_pool.size() > 0) begin
						queue_req(skt_pkg::KIND_DELETE, take_pool_key(1'b1), rand_payload());
					end
					for (n = 0; n < 3; n++) begin
						queue_req(skt_pkg::KIND_DELETE, rand_key(), rand_payload());
					end
				end
				default: begin
					for (n = 0; n < 90; n++) begin
						r = $urandom_range(0, 99);
						if (r < 40) begin
							k = ($urandom_range(0, 9) < 3) ? take_pool_key(1'b0) : rand_key();
							key_pool.push_back(k);
							queue_req(skt_pkg::KIND_INSERT, k, rand_payload());
						end else if (r < 70) begin
							k = ($urandom_range(0, 3) != 0) ? take_pool_key(1'b0) : rand_key();
							queue_req(skt_pkg::KIND_SEARCH, k, rand_payload());
						end else if (r < 95) begin
							k = ($urandom_range(0, 3) != 0) ? take_pool_key(1'b1) : rand_key();
							queue_req(skt_pkg::KIND_DELETE, k, rand_payload());
						end else begin
							queue_req(KIND_UNUSED, rand_key(), rand_payload());
						end
					end
				end
			endcase
			// The sender holds off here until every outstanding result is back.
			wait_drained();
			phase_no++;
		end

		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_rsp.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
